// ===== rtl/core/q2r_pkg.sv =====
// ----------------------------------------------------------------------------
// q2r_pkg
// Shared types and constants of the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package q2r_pkg;

	localparam int OUT_WIDTH    = 16;
	localparam int NUM_ENTRIES  = 9;
	localparam int NUM_PRODUCTS = 10;

	// Product slots of the multiplier stage.
	localparam int P_XX = 0;
	localparam int P_YY = 1;
	localparam int P_ZZ = 2;
	localparam int P_WW = 3;
	localparam int P_XY = 4;
	localparam int P_XZ = 5;
	localparam int P_YZ = 6;
	localparam int P_WX = 7;
	localparam int P_WY = 8;
	localparam int P_WZ = 9;

	// Matrix entry lanes, row by row.
	localparam int E_I_X = 0;
	localparam int E_I_Y = 1;
	localparam int E_I_Z = 2;
	localparam int E_J_X = 3;
	localparam int E_J_Y = 4;
	localparam int E_J_Z = 5;
	localparam int E_K_X = 6;
	localparam int E_K_Y = 7;
	localparam int E_K_Z = 8;

	typedef struct packed {
		logic valid;
		logic zero;
	} q2r_ctl_t;

endpackage

// ===== rtl/core/q2r_prod.sv =====
// ----------------------------------------------------------------------------
// q2r_prod
// First stage: halves an all-even quaternion and forms the ten products.
// ----------------------------------------------------------------------------
module q2r_prod
	import q2r_pkg::*;
#(
	parameter int IN_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [IN_WIDTH-1:0]   qx,
	input  logic signed [IN_WIDTH-1:0]   qy,
	input  logic signed [IN_WIDTH-1:0]   qz,
	input  logic signed [IN_WIDTH-1:0]   qw,
	output logic                         valid_s1,
	output logic signed [2*IN_WIDTH-1:0] prod_s1 [NUM_PRODUCTS]
);

	localparam int PW = 2 * IN_WIDTH;

	logic                 all_even;
	logic signed [PW-1:0] ex, ey, ez, ew;
	logic signed [PW-1:0] prod_c [NUM_PRODUCTS];

	always_comb begin
		// Halving an all-even quaternion is exact and keeps the norm in range.
		all_even = ~(qx[0] | qy[0] | qz[0] | qw[0]);
		ex = all_even ? PW'(qx >>> 1) : PW'(qx);
		ey = all_even ? PW'(qy >>> 1) : PW'(qy);
		ez = all_even ? PW'(qz >>> 1) : PW'(qz);
		ew = all_even ? PW'(qw >>> 1) : PW'(qw);
		prod_c[P_XX] = ex * ex;
		prod_c[P_YY] = ey * ey;
		prod_c[P_ZZ] = ez * ez;
		prod_c[P_WW] = ew * ew;
		prod_c[P_XY] = ex * ey;
		prod_c[P_XZ] = ex * ez;
		prod_c[P_YZ] = ey * ez;
		prod_c[P_WX] = ew * ex;
		prod_c[P_WY] = ew * ey;
		prod_c[P_WZ] = ew * ez;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
	end

endmodule

// ===== rtl/core/q2r_sum.sv =====
// ----------------------------------------------------------------------------
// q2r_sum
// Second and third stages: norm and signed numerators, then magnitudes.
// ----------------------------------------------------------------------------
module q2r_sum
	import q2r_pkg::*;
#(
	parameter int IN_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_s1,
	input  logic signed [2*IN_WIDTH-1:0] prod_s1 [NUM_PRODUCTS],
	output q2r_ctl_t                     ctl_s3,
	output logic        [2*IN_WIDTH:0]   n_s3,
	output logic        [2*IN_WIDTH:0]   mag_s3 [NUM_ENTRIES],
	output logic                         neg_s3 [NUM_ENTRIES]
);

	localparam int NB = 2 * IN_WIDTH + 1;
	localparam int NS = 2 * IN_WIDTH + 2;

	logic signed [NS-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
	logic signed [NS-1:0] num_c  [NUM_ENTRIES];
	logic        [NB-1:0] n_c;
	logic                 valid_s2;
	logic signed [NS-1:0] num_s2 [NUM_ENTRIES];
	logic        [NB-1:0] n_s2;
	logic signed [NS-1:0] abs_c  [NUM_ENTRIES];
	logic        [NB-1:0] mag_c  [NUM_ENTRIES];
	logic                 neg_c  [NUM_ENTRIES];

	always_comb begin
		xx = NS'(prod_s1[P_XX]);
		yy = NS'(prod_s1[P_YY]);
		zz = NS'(prod_s1[P_ZZ]);
		ww = NS'(prod_s1[P_WW]);
		xy = NS'(prod_s1[P_XY]);
		xz = NS'(prod_s1[P_XZ]);
		yz = NS'(prod_s1[P_YZ]);
		wx = NS'(prod_s1[P_WX]);
		wy = NS'(prod_s1[P_WY]);
		wz = NS'(prod_s1[P_WZ]);
		n_c = NB'(xx + yy + zz + ww);
		num_c[E_I_X] = ww + xx - yy - zz;
		num_c[E_J_Y] = ww + yy - xx - zz;
		num_c[E_K_Z] = ww + zz - xx - yy;
		num_c[E_I_Y] = (xy + wz) <<< 1;
		num_c[E_J_X] = (xy - wz) <<< 1;
		num_c[E_I_Z] = (xz - wy) <<< 1;
		num_c[E_K_X] = (xz + wy) <<< 1;
		num_c[E_J_Z] = (yz + wx) <<< 1;
		num_c[E_K_Y] = (yz - wx) <<< 1;
	end

	always_comb begin
		for (int k = 0; k < NUM_ENTRIES; k++) begin
			neg_c[k] = num_s2[k][NS-1];
			abs_c[k] = neg_c[k] ? -num_s2[k] : num_s2[k];
			mag_c[k] = abs_c[k][NB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			ctl_s3   <= '0;
		end else begin
			valid_s2     <= valid_s1;
			ctl_s3.valid <= valid_s2;
			ctl_s3.zero  <= (n_s2 == '0);
		end
	end

	always_ff @(posedge clk) begin
		n_s2   <= n_c;
		num_s2 <= num_c;
		n_s3   <= n_s2;
		mag_s3 <= mag_c;
		neg_s3 <= neg_c;
	end

	// Every numerator is bounded by the norm, so each quotient stays within one; three lanes are checked.
	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid |-> (mag_s3[E_I_X] <= n_s3) && (mag_s3[E_I_Y] <= n_s3)
			&& (mag_s3[E_K_Y] <= n_s3))
		else $error("numerator magnitude exceeds norm");

endmodule

// ===== rtl/core/q2r_div.sv =====
// ----------------------------------------------------------------------------
// q2r_div
// Pipelined restoring divider, nine lanes sharing one divisor, one quotient
// bit per stage, followed by a round-to-nearest stage.
// ----------------------------------------------------------------------------
module q2r_div
	import q2r_pkg::*;
#(
	parameter int IN_WIDTH  = 16,
	parameter int FRAC_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  q2r_ctl_t              ctl_in,
	input  logic [2*IN_WIDTH:0]   n_in,
	input  logic [2*IN_WIDTH:0]   mag_in [NUM_ENTRIES],
	input  logic                  neg_in [NUM_ENTRIES],
	output q2r_ctl_t              ctl_out,
	output logic [FRAC_BITS:0]    q_out  [NUM_ENTRIES],
	output logic                  neg_out [NUM_ENTRIES]
);

	localparam int NB    = 2 * IN_WIDTH + 1;
	localparam int QB    = FRAC_BITS + 1;
	localparam int STEPS = FRAC_BITS + 1;
	localparam logic [QB-1:0] Q_MAX = {1'b1, {FRAC_BITS{1'b0}}};

	q2r_ctl_t      ctl_s [STEPS];
	logic [NB-1:0] n_s   [STEPS];
	logic [NB-1:0] r_s   [STEPS][NUM_ENTRIES];
	logic [QB-1:0] q_s   [STEPS][NUM_ENTRIES];
	logic          neg_s [STEPS][NUM_ENTRIES];

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		q2r_ctl_t      ctl_p;
		logic [NB-1:0] n_p;
		logic [NB-1:0] r_p   [NUM_ENTRIES];
		logic [QB-1:0] q_p   [NUM_ENTRIES];
		logic          neg_p [NUM_ENTRIES];
		logic [NB:0]   t_c   [NUM_ENTRIES];
		logic          ge_c  [NUM_ENTRIES];
		logic [NB-1:0] rn_c  [NUM_ENTRIES];

		if (g == 0) begin : g_first
			assign ctl_p = ctl_in;
			assign n_p   = n_in;
			assign r_p   = mag_in;
			assign q_p   = '{default: '0};
			assign neg_p = neg_in;
		end else begin : g_next
			assign ctl_p = ctl_s[g-1];
			assign n_p   = n_s[g-1];
			assign r_p   = r_s[g-1];
			assign q_p   = q_s[g-1];
			assign neg_p = neg_s[g-1];
		end

		always_comb begin
			for (int k = 0; k < NUM_ENTRIES; k++) begin
				// The first step compares the numerator itself; later ones double the remainder.
				t_c[k]  = (g == 0) ? {1'b0, r_p[k]} : {r_p[k], 1'b0};
				ge_c[k] = (t_c[k] >= {1'b0, n_p});
				rn_c[k] = ge_c[k] ? NB'(t_c[k] - {1'b0, n_p}) : t_c[k][NB-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g] <= '0;
			end else begin
				ctl_s[g] <= ctl_p;
			end
		end

		always_ff @(posedge clk) begin
			n_s[g]   <= n_p;
			neg_s[g] <= neg_p;
			for (int k = 0; k < NUM_ENTRIES; k++) begin
				r_s[g][k] <= rn_c[k];
				q_s[g][k] <= {q_p[k][QB-2:0], ge_c[k]};
			end
		end
	end

	logic          rnd_c [NUM_ENTRIES];

	always_comb begin
		for (int k = 0; k < NUM_ENTRIES; k++) begin
			// Round half up on the magnitude, which is ties away from zero.
			rnd_c[k] = ({r_s[STEPS-1][k], 1'b0} >= {1'b0, n_s[STEPS-1]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		neg_out <= neg_s[STEPS-1];
		for (int k = 0; k < NUM_ENTRIES; k++) begin
			q_out[k] <= q_s[STEPS-1][k] + QB'(rnd_c[k]);
		end
	end

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_out.valid && !ctl_out.zero) |-> (q_out[E_I_X] <= Q_MAX)
			&& (q_out[E_J_Y] <= Q_MAX) && (q_out[E_K_X] <= Q_MAX))
		else $error("rounded quotient exceeds one");

endmodule

// ===== rtl/core/quaternion_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts an unnormalized integer quaternion into the 3x3 rotation matrix,
// each entry a signed fixed-point value rounded to nearest.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Fields
// request   in         start, busy         quat_x, quat_y, quat_z, quat_w
// result    out        valid (one cycle)   i_axis_*, j_axis_*, k_axis_*
//
// One request is taken every cycle; busy stays low.
// The pipeline has one multiply stage, two summing stages, FRAC_BITS + 1
// restoring-division stages, rounding and output.
// The division pipeline, one quotient bit per stage, sets the latency.
// Reset clears all valid bits; data registers are not reset.
// The result is shown for exactly one cycle; there is no back-pressure.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix
	import q2r_pkg::*;
#(
	parameter int IN_WIDTH  = 16,
	parameter int FRAC_BITS = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [IN_WIDTH-1:0] quat_x,
	input  logic signed [IN_WIDTH-1:0] quat_y,
	input  logic signed [IN_WIDTH-1:0] quat_z,
	input  logic signed [IN_WIDTH-1:0] quat_w,
	output logic                       valid,
	output logic signed [OUT_WIDTH-1:0] i_axis_x,
	output logic signed [OUT_WIDTH-1:0] i_axis_y,
	output logic signed [OUT_WIDTH-1:0] i_axis_z,
	output logic signed [OUT_WIDTH-1:0] j_axis_x,
	output logic signed [OUT_WIDTH-1:0] j_axis_y,
	output logic signed [OUT_WIDTH-1:0] j_axis_z,
	output logic signed [OUT_WIDTH-1:0] k_axis_x,
	output logic signed [OUT_WIDTH-1:0] k_axis_y,
	output logic signed [OUT_WIDTH-1:0] k_axis_z
);

	localparam int NB  = 2 * IN_WIDTH + 1;
	localparam int QB  = FRAC_BITS + 1;
	localparam int EW  = (QB + 1 > OUT_WIDTH) ? QB + 1 : OUT_WIDTH;
	localparam int LAT = FRAC_BITS + 6;
	localparam logic [EW-1:0] ONE_E = EW'({1'b1, {FRAC_BITS{1'b0}}});
	localparam logic [OUT_WIDTH-1:0] ONE_OUT = ONE_E[OUT_WIDTH-1:0];

	logic                 req;
	logic                 valid_s1;
	logic signed [2*IN_WIDTH-1:0] prod_s1 [NUM_PRODUCTS];
	q2r_ctl_t             ctl_s3;
	logic [NB-1:0]        n_s3;
	logic [NB-1:0]        mag_s3 [NUM_ENTRIES];
	logic                 neg_s3 [NUM_ENTRIES];
	q2r_ctl_t             ctl_d;
	logic [QB-1:0]        q_d    [NUM_ENTRIES];
	logic                 neg_d  [NUM_ENTRIES];
	logic signed [EW-1:0] mv_c   [NUM_ENTRIES];
	logic signed [EW-1:0] v_c    [NUM_ENTRIES];
	logic [OUT_WIDTH-1:0] res_c  [NUM_ENTRIES];
	logic [OUT_WIDTH-1:0] res_q  [NUM_ENTRIES];
	logic                 valid_q;

	assign busy = 1'b0;
	assign req  = start && !busy;

	q2r_prod #(
		.IN_WIDTH (IN_WIDTH)
	) u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req),
		.qx       (quat_x),
		.qy       (quat_y),
		.qz       (quat_z),
		.qw       (quat_w),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1)
	);

	q2r_sum #(
		.IN_WIDTH (IN_WIDTH)
	) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.ctl_s3   (ctl_s3),
		.n_s3     (n_s3),
		.mag_s3   (mag_s3),
		.neg_s3   (neg_s3)
	);

	q2r_div #(
		.IN_WIDTH  (IN_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s3),
		.n_in    (n_s3),
		.mag_in  (mag_s3),
		.neg_in  (neg_s3),
		.ctl_out (ctl_d),
		.q_out   (q_d),
		.neg_out (neg_d)
	);

	always_comb begin
		for (int k = 0; k < NUM_ENTRIES; k++) begin
			mv_c[k] = $signed(EW'(q_d[k]));
			v_c[k]  = neg_d[k] ? -mv_c[k] : mv_c[k];
			// A zero quaternion maps to the identity.
			if (ctl_d.zero) begin
				res_c[k] = (k == E_I_X || k == E_J_Y || k == E_K_Z) ? ONE_OUT : '0;
			end else begin
				res_c[k] = v_c[k][OUT_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ctl_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_c;
	end

	assign valid    = valid_q;
	assign i_axis_x = res_q[E_I_X];
	assign i_axis_y = res_q[E_I_Y];
	assign i_axis_z = res_q[E_I_Z];
	assign j_axis_x = res_q[E_J_X];
	assign j_axis_y = res_q[E_J_Y];
	assign j_axis_z = res_q[E_J_Z];
	assign k_axis_x = res_q[E_K_X];
	assign k_axis_y = res_q[E_K_Y];
	assign k_axis_z = res_q[E_K_Z];

	a_req_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		req |-> ##LAT valid)
		else $error("request did not produce a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!req |-> ##LAT !valid)
		else $error("result without a request");

	a_zero_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(req && quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0)
			|-> ##LAT (i_axis_x == ONE_OUT && j_axis_y == ONE_OUT
			&& k_axis_z == ONE_OUT && i_axis_y == '0 && k_axis_x == '0))
		else $error("zero quaternion did not give the identity");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression of quaternion_to_rotation_matrix. Each request
// taken gets an expected matrix, typed in a directed row or else computed
// exactly and rounded by a behavioral predictor. Each result strobe is
// compared entry by entry against the oldest expected matrix. A short
// directed table first, then 1500 random quaternions, with random request gaps.
// ----------------------------------------------------------------------------
module testbench;
	import q2r_pkg::*;

	localparam int IN_W       = 16;
	localparam int FRAC       = 14;
	localparam int LATENCY    = FRAC + 6;
	localparam int RANDOM_CNT = 1500;
	localparam int QUIET_TAIL = 200;
	localparam int STALL_MAX  = 2000;
	localparam int ROW_CNT    = 22;
	localparam int ONE        = 1 << FRAC;

	typedef logic [NUM_ENTRIES-1:0][OUT_WIDTH-1:0] mat_t;

	typedef struct packed {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic signed [IN_W-1:0] z;
		logic signed [IN_W-1:0] w;
		logic                   typed;
		mat_t                   m;
	} row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	logic busy;
	logic signed [IN_W-1:0] quat_x = '0;
	logic signed [IN_W-1:0] quat_y = '0;
	logic signed [IN_W-1:0] quat_z = '0;
	logic signed [IN_W-1:0] quat_w = '0;
	logic valid;
	logic signed [OUT_WIDTH-1:0] i_axis_x, i_axis_y, i_axis_z;
	logic signed [OUT_WIDTH-1:0] j_axis_x, j_axis_y, j_axis_z;
	logic signed [OUT_WIDTH-1:0] k_axis_x, k_axis_y, k_axis_z;

	mat_t pending_matrices[$];
	mat_t next_matrix = '0;
	bit   req_taken = 1'b0;
	int   mismatches = 0;
	int   quiet_cycles = 0;

	string lane_name [NUM_ENTRIES] = '{"i_axis_x", "i_axis_y", "i_axis_z",
		"j_axis_x", "j_axis_y", "j_axis_z", "k_axis_x", "k_axis_y", "k_axis_z"};

	quaternion_to_rotation_matrix #(
		.IN_WIDTH (IN_W),
		.FRAC_BITS(FRAC)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.quat_x  (quat_x),
		.quat_y  (quat_y),
		.quat_z  (quat_z),
		.quat_w  (quat_w),
		.valid   (valid),
		.i_axis_x(i_axis_x),
		.i_axis_y(i_axis_y),
		.i_axis_z(i_axis_z),
		.j_axis_x(j_axis_x),
		.j_axis_y(j_axis_y),
		.j_axis_z(j_axis_z),
		.k_axis_x(k_axis_x),
		.k_axis_y(k_axis_y),
		.k_axis_z(k_axis_z)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic mat_t diag_of(input int a, input int b, input int c);
		mat_t m;
		m = '0;
		m[E_I_X] = OUT_WIDTH'(a);
		m[E_J_Y] = OUT_WIDTH'(b);
		m[E_K_Z] = OUT_WIDTH'(c);
		return m;
	endfunction

	// Rounds num / n (doubled when asked) to FRAC fraction bits, ties away from zero.
	function automatic logic [OUT_WIDTH-1:0] fixed_ratio(input longint num,
			input longint n, input bit doubled);
		longint mag, q, r;
		mag = (num < 0) ? -num : num;
		if (doubled) begin
			mag = mag * 2;
		end
		mag = mag << FRAC;
		q = mag / n;
		r = mag - q * n;
		if (2 * r >= n) begin
			q = q + 1;
		end
		if (num < 0) begin
			q = -q;
		end
		return q[OUT_WIDTH-1:0];
	endfunction

	function automatic mat_t rotation_of(input logic signed [IN_W-1:0] qx,
			input logic signed [IN_W-1:0] qy, input logic signed [IN_W-1:0] qz,
			input logic signed [IN_W-1:0] qw);
		longint x, y, z, w, xx, yy, zz, ww, n;
		mat_t m;
		x = longint'(qx);
		y = longint'(qy);
		z = longint'(qz);
		w = longint'(qw);
		// Halving an all-even quaternion is exact and keeps the norm small.
		if (((x | y | z | w) & 1) == 0) begin
			x = x / 2;
			y = y / 2;
			z = z / 2;
			w = w / 2;
		end
		xx = x * x;
		yy = y * y;
		zz = z * z;
		ww = w * w;
		n = xx + yy + zz + ww;
		if (n == 0) begin
			return diag_of(ONE, ONE, ONE);
		end
		m[E_I_X] = fixed_ratio(ww + xx - yy - zz, n, 1'b0);
		m[E_J_Y] = fixed_ratio(ww + yy - xx - zz, n, 1'b0);
		m[E_K_Z] = fixed_ratio(ww + zz - xx - yy, n, 1'b0);
		m[E_I_Y] = fixed_ratio(x * y + w * z, n, 1'b1);
		m[E_J_X] = fixed_ratio(x * y - w * z, n, 1'b1);
		m[E_I_Z] = fixed_ratio(x * z - w * y, n, 1'b1);
		m[E_K_X] = fixed_ratio(x * z + w * y, n, 1'b1);
		m[E_J_Z] = fixed_ratio(y * z + w * x, n, 1'b1);
		m[E_K_Y] = fixed_ratio(y * z - w * x, n, 1'b1);
		return m;
	endfunction

	// Rows with a typed matrix are the identity and the half-turns about an axis.
	row_t directed_rows [ROW_CNT] = '{
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, diag_of(ONE, ONE, ONE)},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd1, 1'b1, diag_of(ONE, ONE, ONE)},
		'{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 1'b1, diag_of(ONE, ONE, ONE)},
		'{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b1, diag_of(ONE, -ONE, -ONE)},
		'{16'sd0, -16'sd32768, 16'sd0, 16'sd0, 1'b1, diag_of(-ONE, ONE, -ONE)},
		'{16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b1, diag_of(-ONE, -ONE, ONE)},
		'{-16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1, diag_of(ONE, -ONE, -ONE)},
		'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
		'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
		'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, '0},
		'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0, '0},
		'{16'sd1, 16'sd0, 16'sd0, 16'sd1, 1'b0, '0},
		'{16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b0, '0},
		'{16'sd0, 16'sd0, 16'sd1, 16'sd1, 1'b0, '0},
		'{16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b0, '0},
		'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, '0},
		'{16'sd2, 16'sd4, -16'sd6, 16'sd8, 1'b0, '0},
		'{16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b0, '0},
		'{-16'sd32768, 16'sd0, 16'sd0, 16'sd32767, 1'b0, '0},
		'{16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 1'b0, '0},
		'{16'sd12345, -16'sd23456, 16'sd345, -16'sd7, 1'b0, '0},
		'{16'sd0, 16'sd0, -16'sd32768, -16'sd32768, 1'b0, '0}
	};

	// Request and result sampling on the rising edge.
	always @(posedge clk) begin
		mat_t got, want;
		got = {k_axis_z, k_axis_y, k_axis_x, j_axis_z, j_axis_y, j_axis_x,
			i_axis_z, i_axis_y, i_axis_x};
		req_taken = arst_n && start && !busy;
		if (req_taken) begin
			pending_matrices.push_back(next_matrix);
		end
		if (arst_n && valid) begin
			if (pending_matrices.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = pending_matrices.pop_front();
				for (int k = 0; k < NUM_ENTRIES; k++) begin
					if (got[k] !== want[k]) begin
						$error("%s: expected %0d, actual %0d", lane_name[k],
							$signed(want[k]), $signed(got[k]));
						mismatches++;
					end
				end
			end
		end
		if (req_taken || (arst_n && valid)) begin
			quiet_cycles = 0;
		end else if (arst_n) begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_MAX) begin
			$display("quaternion_to_rotation_matrix regression: fail");
			$finish;
		end
	end

	task automatic send_quat(input logic signed [IN_W-1:0] qx,
			input logic signed [IN_W-1:0] qy, input logic signed [IN_W-1:0] qz,
			input logic signed [IN_W-1:0] qw, input logic typed, input mat_t given);
		next_matrix = typed ? given : rotation_of(qx, qy, qz, qw);
		start  <= 1'b1;
		quat_x <= qx;
		quat_y <= qy;
		quat_z <= qz;
		quat_w <= qw;
		do begin
			@(negedge clk);
		end while (!req_taken);
	endtask

	initial begin
		logic signed [IN_W-1:0] q [4];
		logic signed [IN_W-1:0] edge_vals [6];
		int kind;
		int big;
		edge_vals = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < ROW_CNT; r++) begin
			send_quat(directed_rows[r].x, directed_rows[r].y, directed_rows[r].z,
				directed_rows[r].w, directed_rows[r].typed, directed_rows[r].m);
			if ($urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
		end

		for (int i = 0; i < RANDOM_CNT; i++) begin
			kind = $urandom_range(0, 9);
			big = $urandom_range(0, 3);
			for (int c = 0; c < 4; c++) begin
				case (kind)
					0, 1, 2, 3: begin
						q[c] = IN_W'($urandom);
					end
					4, 5: begin
						q[c] = IN_W'($urandom_range(0, 18) - 9);
					end
					6: begin
						// All-even quaternions take the halving path.
						q[c] = IN_W'($urandom << $urandom_range(1, 4));
					end
					7: begin
						q[c] = ($urandom_range(0, 1) == 1) ? IN_W'($urandom) : '0;
					end
					8: begin
						q[c] = edge_vals[$urandom_range(0, 5)];
					end
					default: begin
						q[c] = (c == big) ? IN_W'($urandom) : IN_W'($urandom_range(0, 6) - 3);
					end
				endcase
			end
			send_quat(q[0], q[1], q[2], q[3], 1'b0, '0);
			if (i < RANDOM_CNT - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
		end
		start <= 1'b0;

		while (pending_matrices.size() != 0) begin
			@(negedge clk);
		end
		repeat (2 * LATENCY) @(negedge clk);
		if (mismatches == 0) begin
			$display("quaternion_to_rotation_matrix regression: pass");
		end else begin
			$display("quaternion_to_rotation_matrix regression: fail");
		end
		$finish;
	end

endmodule
